// File: rtl/bytecode_vm_execute_unit_macros.svh
// Assertion macros used by the checker file of the execute unit
`ifndef BYTECODE_VM_EXECUTE_UNIT_MACROS_SVH
`define BYTECODE_VM_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define BVM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define BVM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bvm_pkg.sv
// Shared constants, codes, request structs and the font table of the execute unit
`timescale 1ns / 1ps
package bvm_pkg;
	localparam int MEM_BYTES   = 4096;
	localparam int ADDR_W      = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SI_W        = $clog2(STACK_DEPTH);
	localparam int SCR_W       = 64;
	localparam int SCR_H       = 32;
	localparam int ROW_W       = $clog2(SCR_H);
	localparam int COL_W       = $clog2(SCR_W);
	localparam int GLYPH_BYTES = 5;
	localparam int FONT_BYTES  = 80;
	localparam int REG_N       = 16;
	localparam int REG_AW      = $clog2(REG_N);

	localparam logic [SP_W-1:0]   SP_FULL   = SP_W'(STACK_DEPTH);
	localparam logic [REG_AW-1:0] VF_IDX    = REG_AW'(REG_N - 1);
	localparam logic [11:0]       PC_RESET_START = 12'd512;

	// item kinds
	localparam logic [1:0] KIND_EXEC = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_ROW  = 2'd3;

	// major opcodes
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEQI = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SEQR = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDIX = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [15:0] SYS_CLS = 16'h00E0;
	localparam logic [15:0] SYS_RET = 16'h00EE;

	// ALU sub-codes
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// key sub-codes
	localparam logic [7:0] KEY_SKP  = 8'h9E;
	localparam logic [7:0] KEY_SKNP = 8'hA1;

	// misc sub-codes
	localparam logic [7:0] FX_LD_DT  = 8'h07;
	localparam logic [7:0] FX_LD_KEY = 8'h0A;
	localparam logic [7:0] FX_ST_DT  = 8'h15;
	localparam logic [7:0] FX_ST_ST  = 8'h18;
	localparam logic [7:0] FX_ADD_I  = 8'h1E;
	localparam logic [7:0] FX_FONT   = 8'h29;
	localparam logic [7:0] FX_BCD    = 8'h33;
	localparam logic [7:0] FX_STORE  = 8'h55;
	localparam logic [7:0] FX_LOAD   = 8'h65;

	// stack fault codes
	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_PUSH = 2'd1;
	localparam logic [1:0] FAULT_POP  = 2'd2;

	// result bit positions watched by the checker
	localparam int OB_COLL = 44;
	localparam int OB_CHG  = 45;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic              we;
		logic [REG_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic [REG_AW-1:0] raddr;
	} reg_req_t;

	typedef struct packed {
		logic             we;
		logic             clear;
		logic [ROW_W-1:0] addr;
		logic [SCR_W-1:0] wdata;
	} frame_req_t;

	function automatic logic [7:0] font_byte(input logic [6:0] a);
		logic [7:0] f;
		case (a)
			7'd0: f = 8'hF0;  7'd1: f = 8'h90;  7'd2: f = 8'h90;  7'd3: f = 8'h90;
			7'd4: f = 8'hF0;  7'd5: f = 8'h20;  7'd6: f = 8'h60;  7'd7: f = 8'h20;
			7'd8: f = 8'h20;  7'd9: f = 8'h70;  7'd10: f = 8'hF0; 7'd11: f = 8'h10;
			7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
			7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
			7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
			7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
			7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
			7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
			7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
			7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
			7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
			7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
			7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
			7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
			7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
			7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
			7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
			7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
			7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
			default: f = 8'h00;
		endcase
		return f;
	endfunction
endpackage

// File: rtl/bvm_mem.sv
// Main byte memory with a font-loading clearing pass after reset
`timescale 1ns / 1ps
module bvm_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bvm_pkg::mem_req_t             req,
	output logic [7:0]                    rdata,
	output logic                          busy
);
	logic [7:0]                   mem [bvm_pkg::MEM_BYTES];
	logic [bvm_pkg::ADDR_W-1:0]   clr_q;
	logic                         busy_q;
	logic [7:0]                   rd_q;
	logic                         wr_en;
	logic [bvm_pkg::ADDR_W-1:0]   wr_addr;
	logic [7:0]                   wr_data;
	logic [7:0]                   clr_data;

	assign clr_data = (clr_q < bvm_pkg::ADDR_W'(bvm_pkg::FONT_BYTES)) ?
		bvm_pkg::font_byte(clr_q[6:0]) : 8'd0;
	assign wr_en   = busy_q | req.we;
	assign wr_addr = busy_q ? clr_q : req.addr;
	assign wr_data = busy_q ? clr_data : req.wdata;

	// sweep every address once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (&clr_q) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[req.addr];
	end

	assign rdata = rd_q;
	assign busy  = busy_q;
endmodule

// File: rtl/bvm_regfile.sv
// Sixteen byte registers in a small memory, with per-entry valid bits for reset
`timescale 1ns / 1ps
module bvm_regfile (
	input  logic              clk,
	input  logic              arst_n,
	input  bvm_pkg::reg_req_t req,
	output logic [7:0]        rdata
);
	logic [7:0]                rf [bvm_pkg::REG_N];
	logic [bvm_pkg::REG_N-1:0] valid_q;
	logic [7:0]                rd_q;
	logic                      rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.we) valid_q[req.waddr] <= 1'b1;
			rvalid_q <= valid_q[req.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) rf[req.waddr] <= req.wdata;
		rd_q <= rf[req.raddr];
	end

	// an entry never written reads as zero
	assign rdata = rvalid_q ? rd_q : 8'd0;
endmodule

// File: rtl/bvm_frame.sv
// Frame store memory with a lit flag per row for reset, clear and change detection
`timescale 1ns / 1ps
module bvm_frame (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bvm_pkg::frame_req_t       req,
	output logic [bvm_pkg::SCR_W-1:0] rdata,
	output logic                      any_lit
);
	logic [bvm_pkg::SCR_W-1:0] fs [bvm_pkg::SCR_H];
	logic [bvm_pkg::SCR_H-1:0] lit_q;
	logic [bvm_pkg::SCR_W-1:0] rd_q;
	logic                      rlit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q  <= '0;
			rlit_q <= 1'b0;
		end else begin
			if (req.clear) lit_q <= '0;
			else if (req.we) lit_q[req.addr] <= |req.wdata;
			rlit_q <= lit_q[req.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) fs[req.addr] <= req.wdata;
		rd_q <= fs[req.addr];
	end

	// a dark row reads as zero whatever the array holds
	assign rdata   = rlit_q ? rd_q : '0;
	assign any_lit = |lit_q;
endmodule

// File: rtl/bytecode_vm_execute_unit.sv
// Top level of the bytecode VM execute unit: sequencer, architectural registers, result register
`timescale 1ns / 1ps
// Usage:
//   Requests enter on the s_ channel; s_tuser carries the kind (execute, load program
//   byte, timer tick, read screen row), s_tdata the remaining fields. Every request
//   yields one result on the m_ channel with PC, index, timers, draw flags, stack
//   fault and (for row reads) the 64 pixels of the row.
//   cfg_we/cfg_wdata write program_start, the PC value after a load request.
// Timing:
//   One request is in work at a time. A simple request passes ST_RDX, ST_RDY, ST_EXEC
//   and ST_DONE; a draw adds a read and a write state per row and ST_WFLAG, a block
//   store/load of x+1 registers a read and a write state each, BCD ST_BCD1 and ST_BCD2,
//   an ALU op that sets VF ST_WFLAG. The longest is a store or load of all 16 registers.
//   Each row or byte needs a read then a write on the single-port byte memory or frame store.
// Reset:
//   arst_n clears all control state. The byte memory then runs a clearing pass over
//   all 4096 addresses that loads the hex font at 0..79 and zeros the rest; s_tready
//   stays low until it ends. Registers and frame rows read as zero until written.
// Stall:
//   A finished result sits in the output register until m_tready; the next request
//   is accepted meanwhile, and its own result waits in the sequencer until the
//   output register frees up.
module bytecode_vm_execute_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] instruction, [27:16] mem_address, [35:28] mem_data, [43:36] random_byte,
	// [59:44] keys_down, [63:60] wait_key, [68:64] screen_row_index, [71:69] zero
	input  logic [71:0]  s_tdata,
	// [1:0] kind
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [11:0] program_counter, [27:12] index_address, [35:28] delay_count,
	// [43:36] sound_count, [44] collision, [45] screen_changed, [47:46] stack_fault,
	// [111:48] screen_row_bits
	output logic [111:0] m_tdata,
	input  logic         cfg_we,
	input  logic [11:0]  cfg_wdata
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_RDX, ST_RDY, ST_EXEC, ST_WFLAG, ST_ROW,
		ST_DRAW_RD, ST_DRAW_WR, ST_BCD1, ST_BCD2,
		ST_ST_RD, ST_ST_WR, ST_LD_RD, ST_LD_WR, ST_DONE
	} state_t;

	state_t                    state_q;
	state_t                    exec_state;
	logic [11:0]               exec_pc;

	// request fields held for the whole item
	logic [1:0]                kind_q;
	logic [15:0]               instr_q;
	logic [11:0]               maddr_q;
	logic [7:0]                mdata_q;
	logic [7:0]                rnd_q;
	logic [15:0]               keys_q;
	logic [3:0]                pkey_q;
	logic [4:0]                rowi_q;

	// architectural state
	logic [11:0]               pc_q;
	logic [15:0]               idx_q;
	logic [7:0]                delay_q;
	logic [7:0]                sound_q;
	logic [bvm_pkg::SP_W-1:0]  sp_q;
	logic [11:0]               pstart_q;
	logic [11:0]               stack_q [bvm_pkg::STACK_DEPTH];

	// working registers
	logic [7:0]                vx_q;
	logic [7:0]                vy_q;
	logic [3:0]                cnt_q;
	logic                      flag_q;
	logic [6:0]                rem_q;
	logic [3:0]                ones_q;
	logic                      hit_q;
	logic                      chg_q;
	logic [1:0]                fault_q;
	logic [63:0]               row_q;
	logic                      mvalid_q;
	logic [111:0]              out_q;

	bvm_pkg::mem_req_t         mem_req;
	bvm_pkg::reg_req_t         reg_req;
	bvm_pkg::frame_req_t       frm_req;
	logic [7:0]                mem_rdata;
	logic                      mem_busy;
	logic [7:0]                reg_rdata;
	logic [63:0]               frm_rdata;
	logic                      frm_any;

	logic [3:0]                op, xi, yi, ni;
	logic [7:0]                kk;
	logic [11:0]               nnn;
	logic [11:0]               pc_adv, pc_skip;
	logic [11:0]               blk_addr;
	logic [4:0]                draw_row;
	logic [63:0]               sprite;
	logic [127:0]              rot;
	logic [63:0]               draw_mask;
	logic                      hit_next;
	logic [bvm_pkg::SP_W-1:0]  sp_dec;
	logic                      key_down;
	logic                      push;
	logic [7:0]                alu_res;
	logic                      alu_flag, alu_wr, alu_flagged;
	logic [8:0]                add_sum;
	logic [1:0]                bcd_h;
	logic [6:0]                bcd_rem;
	logic [14:0]               tens_prod;
	logic [3:0]                tens;
	logic [6:0]                tens_x10;

	assign op  = instr_q[15:12];
	assign xi  = instr_q[11:8];
	assign yi  = instr_q[7:4];
	assign ni  = instr_q[3:0];
	assign kk  = instr_q[7:0];
	assign nnn = instr_q[11:0];

	assign pc_adv    = pc_q + 12'd2;
	assign pc_skip   = pc_q + 12'd4;
	assign blk_addr  = idx_q[11:0] + 12'(cnt_q);
	assign draw_row  = vy_q[4:0] + 5'(cnt_q);
	// wrap the sprite byte around the row: rotate right by the column
	assign sprite    = {mem_rdata, 56'd0};
	assign rot       = {sprite, sprite} >> vx_q[5:0];
	assign draw_mask = rot[63:0];
	assign hit_next  = hit_q | (|(frm_rdata & draw_mask));
	assign sp_dec    = sp_q - 1'b1;
	assign key_down  = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
	assign push      = (state_q == ST_EXEC) && (kind_q == bvm_pkg::KIND_EXEC) &&
		(op == bvm_pkg::OP_CALL) && (sp_q < bvm_pkg::SP_FULL);

	// ALU; vy comes straight from the register file read port in ST_EXEC
	assign add_sum = {1'b0, vx_q} + {1'b0, reg_rdata};
	always_comb begin
		alu_res     = reg_rdata;
		alu_flag    = 1'b0;
		alu_wr      = 1'b1;
		alu_flagged = 1'b0;
		unique case (ni)
			bvm_pkg::ALU_MOV:  alu_res = reg_rdata;
			bvm_pkg::ALU_OR:   alu_res = vx_q | reg_rdata;
			bvm_pkg::ALU_AND:  alu_res = vx_q & reg_rdata;
			bvm_pkg::ALU_XOR:  alu_res = vx_q ^ reg_rdata;
			bvm_pkg::ALU_ADD: begin
				alu_res = add_sum[7:0]; alu_flag = add_sum[8]; alu_flagged = 1'b1;
			end
			bvm_pkg::ALU_SUB: begin
				alu_res = vx_q - reg_rdata; alu_flag = vx_q >= reg_rdata;
				alu_flagged = 1'b1;
			end
			bvm_pkg::ALU_SHR: begin
				alu_res = {1'b0, vx_q[7:1]}; alu_flag = vx_q[0]; alu_flagged = 1'b1;
			end
			bvm_pkg::ALU_SUBN: begin
				alu_res = reg_rdata - vx_q; alu_flag = reg_rdata >= vx_q;
				alu_flagged = 1'b1;
			end
			bvm_pkg::ALU_SHL: begin
				alu_res = {vx_q[6:0], 1'b0}; alu_flag = vx_q[7]; alu_flagged = 1'b1;
			end
			default: alu_wr = 1'b0;
		endcase
	end

	// BCD: hundreds by compare/subtract, tens by reciprocal multiply of the remainder
	always_comb begin
		if (vx_q >= 8'd200) begin
			bcd_h = 2'd2; bcd_rem = 7'(vx_q - 8'd200);
		end else if (vx_q >= 8'd100) begin
			bcd_h = 2'd1; bcd_rem = 7'(vx_q - 8'd100);
		end else begin
			bcd_h = 2'd0; bcd_rem = vx_q[6:0];
		end
	end
	assign tens_prod = 15'(rem_q) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign tens_x10  = (7'(tens) << 3) + (7'(tens) << 1);

	// next PC and next state out of ST_EXEC
	always_comb begin
		exec_pc    = pc_q;
		exec_state = ST_DONE;
		unique case (kind_q)
			bvm_pkg::KIND_LOAD: exec_pc = pstart_q;
			bvm_pkg::KIND_TICK: ;
			bvm_pkg::KIND_ROW: exec_state = ST_ROW;
			bvm_pkg::KIND_EXEC: begin
				exec_pc = pc_adv;
				unique case (op)
					bvm_pkg::OP_SYS: begin
						if (instr_q == bvm_pkg::SYS_RET && sp_q != '0)
							exec_pc = stack_q[sp_dec[bvm_pkg::SI_W-1:0]];
					end
					bvm_pkg::OP_JP: exec_pc = nnn;
					bvm_pkg::OP_CALL: if (push) exec_pc = nnn;
					bvm_pkg::OP_SEQI: if (vx_q == kk) exec_pc = pc_skip;
					bvm_pkg::OP_SNEI: if (vx_q != kk) exec_pc = pc_skip;
					bvm_pkg::OP_SEQR: if (vx_q == reg_rdata) exec_pc = pc_skip;
					bvm_pkg::OP_SNER: if (vx_q != reg_rdata) exec_pc = pc_skip;
					bvm_pkg::OP_ALU: if (alu_flagged) exec_state = ST_WFLAG;
					bvm_pkg::OP_JPV0: exec_pc = nnn + 12'(reg_rdata);
					bvm_pkg::OP_DRW:
						exec_state = (ni == 4'd0) ? ST_WFLAG : ST_DRAW_RD;
					bvm_pkg::OP_KEY: begin
						if ((kk == bvm_pkg::KEY_SKP && key_down) ||
							(kk == bvm_pkg::KEY_SKNP && !key_down))
							exec_pc = pc_skip;
					end
					bvm_pkg::OP_MISC: begin
						if (kk == bvm_pkg::FX_BCD) exec_state = ST_BCD1;
						else if (kk == bvm_pkg::FX_STORE) exec_state = ST_ST_RD;
						else if (kk == bvm_pkg::FX_LOAD) exec_state = ST_LD_RD;
					end
					default: ;
				endcase
			end
		endcase
	end

	// memory requests, one port each
	always_comb begin
		mem_req       = '0;
		mem_req.addr  = blk_addr;
		reg_req       = '0;
		reg_req.waddr = xi;
		reg_req.raddr = xi;
		frm_req       = '0;
		frm_req.addr  = draw_row;
		frm_req.wdata = frm_rdata ^ draw_mask;
		unique case (state_q)
			ST_RDY: reg_req.raddr = (op == bvm_pkg::OP_JPV0) ? '0 : yi;
			ST_EXEC: begin
				unique case (kind_q)
					bvm_pkg::KIND_LOAD: begin
						mem_req.we = 1'b1; mem_req.addr = maddr_q; mem_req.wdata = mdata_q;
					end
					bvm_pkg::KIND_ROW: frm_req.addr = rowi_q;
					bvm_pkg::KIND_TICK: ;
					bvm_pkg::KIND_EXEC: begin
						unique case (op)
							bvm_pkg::OP_SYS:  frm_req.clear = (instr_q == bvm_pkg::SYS_CLS);
							bvm_pkg::OP_LDI: begin
								reg_req.we = 1'b1; reg_req.wdata = kk;
							end
							bvm_pkg::OP_ADDI: begin
								reg_req.we = 1'b1; reg_req.wdata = vx_q + kk;
							end
							bvm_pkg::OP_ALU: begin
								reg_req.we = alu_wr; reg_req.wdata = alu_res;
							end
							bvm_pkg::OP_RND: begin
								reg_req.we = 1'b1; reg_req.wdata = rnd_q & kk;
							end
							bvm_pkg::OP_MISC: begin
								if (kk == bvm_pkg::FX_LD_DT) begin
									reg_req.we = 1'b1; reg_req.wdata = delay_q;
								end else if (kk == bvm_pkg::FX_LD_KEY) begin
									reg_req.we = 1'b1; reg_req.wdata = {4'd0, pkey_q};
								end else if (kk == bvm_pkg::FX_BCD) begin
									mem_req.we = 1'b1; mem_req.addr = idx_q[11:0];
									mem_req.wdata = {6'd0, bcd_h};
								end
							end
							default: ;
						endcase
					end
				endcase
			end
			ST_WFLAG: begin
				reg_req.we = 1'b1; reg_req.waddr = bvm_pkg::VF_IDX;
				reg_req.wdata = {7'd0, flag_q};
			end
			ST_DRAW_WR: frm_req.we = 1'b1;
			ST_BCD1: begin
				mem_req.we = 1'b1; mem_req.addr = idx_q[11:0] + 12'd1;
				mem_req.wdata = {4'd0, tens};
			end
			ST_BCD2: begin
				mem_req.we = 1'b1; mem_req.addr = idx_q[11:0] + 12'd2;
				mem_req.wdata = {4'd0, ones_q};
			end
			ST_ST_RD: reg_req.raddr = cnt_q;
			ST_ST_WR: begin
				mem_req.we = 1'b1; mem_req.wdata = reg_rdata;
			end
			ST_LD_WR: begin
				reg_req.we = 1'b1; reg_req.waddr = cnt_q; reg_req.wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	bvm_mem u_mem (
		.clk(clk), .arst_n(arst_n), .req(mem_req), .rdata(mem_rdata), .busy(mem_busy)
	);
	bvm_regfile u_regs (
		.clk(clk), .arst_n(arst_n), .req(reg_req), .rdata(reg_rdata)
	);
	bvm_frame u_frame (
		.clk(clk), .arst_n(arst_n), .req(frm_req), .rdata(frm_rdata), .any_lit(frm_any)
	);

	assign s_tready = (state_q == ST_IDLE) && !mem_busy;
	assign m_tvalid = mvalid_q;
	assign m_tdata  = out_q;

	// return stack entries: payload only, never read before pushed
	always_ff @(posedge clk) begin
		if (push) stack_q[sp_q[bvm_pkg::SI_W-1:0]] <= pc_adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= bvm_pkg::KIND_EXEC;
			instr_q  <= '0;
			maddr_q  <= '0;
			mdata_q  <= '0;
			rnd_q    <= '0;
			keys_q   <= '0;
			pkey_q   <= '0;
			rowi_q   <= '0;
			pc_q     <= '0;
			idx_q    <= '0;
			delay_q  <= '0;
			sound_q  <= '0;
			sp_q     <= '0;
			pstart_q <= bvm_pkg::PC_RESET_START;
			vx_q     <= '0;
			vy_q     <= '0;
			cnt_q    <= '0;
			flag_q   <= 1'b0;
			rem_q    <= '0;
			ones_q   <= '0;
			hit_q    <= 1'b0;
			chg_q    <= 1'b0;
			fault_q  <= bvm_pkg::FAULT_NONE;
			row_q    <= '0;
			mvalid_q <= 1'b0;
			out_q    <= '0;
		end else begin
			if (cfg_we) pstart_q <= cfg_wdata;
			// drop the result once taken, unless a new one replaces it below
			if (mvalid_q && m_tready && state_q != ST_DONE) mvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						kind_q  <= s_tuser;
						instr_q <= s_tdata[15:0];
						maddr_q <= s_tdata[27:16];
						mdata_q <= s_tdata[35:28];
						rnd_q   <= s_tdata[43:36];
						keys_q  <= s_tdata[59:44];
						pkey_q  <= s_tdata[63:60];
						rowi_q  <= s_tdata[68:64];
						hit_q   <= 1'b0;
						chg_q   <= 1'b0;
						fault_q <= bvm_pkg::FAULT_NONE;
						row_q   <= '0;
						state_q <= ST_RDX;
					end
				end
				ST_RDX: state_q <= ST_RDY;
				ST_RDY: begin
					vx_q    <= reg_rdata;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= exec_state;
					pc_q    <= exec_pc;
					vy_q    <= reg_rdata;
					unique case (kind_q)
						bvm_pkg::KIND_TICK: begin
							if (delay_q != 8'd0) delay_q <= delay_q - 8'd1;
							if (sound_q != 8'd0) sound_q <= sound_q - 8'd1;
						end
						bvm_pkg::KIND_EXEC: begin
							unique case (op)
								bvm_pkg::OP_SYS: begin
									if (instr_q == bvm_pkg::SYS_CLS) begin
										chg_q <= frm_any;
									end else if (instr_q == bvm_pkg::SYS_RET) begin
										if (sp_q == '0) fault_q <= bvm_pkg::FAULT_POP;
										else sp_q <= sp_dec;
									end
								end
								bvm_pkg::OP_CALL: begin
									if (push) sp_q <= sp_q + 1'b1;
									else fault_q <= bvm_pkg::FAULT_PUSH;
								end
								bvm_pkg::OP_ALU: if (alu_flagged) flag_q <= alu_flag;
								bvm_pkg::OP_LDIX: idx_q <= {4'd0, nnn};
								bvm_pkg::OP_DRW: begin
									cnt_q <= '0;
									if (ni == 4'd0) flag_q <= 1'b0;
								end
								bvm_pkg::OP_MISC: begin
									cnt_q <= '0;
									if (kk == bvm_pkg::FX_ST_DT) delay_q <= vx_q;
									else if (kk == bvm_pkg::FX_ST_ST) sound_q <= vx_q;
									else if (kk == bvm_pkg::FX_ADD_I) idx_q <= idx_q + 16'(vx_q);
									else if (kk == bvm_pkg::FX_FONT)
										idx_q <= 16'(vx_q) * 16'(bvm_pkg::GLYPH_BYTES);
									else if (kk == bvm_pkg::FX_BCD) rem_q <= bcd_rem;
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				ST_WFLAG: state_q <= ST_DONE;
				ST_ROW: begin
					row_q   <= frm_rdata;
					state_q <= ST_DONE;
				end
				ST_DRAW_RD: state_q <= ST_DRAW_WR;
				ST_DRAW_WR: begin
					hit_q <= hit_next;
					chg_q <= chg_q | (|draw_mask);
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == ni - 4'd1) begin
						flag_q  <= hit_next;
						state_q <= ST_WFLAG;
					end else begin
						state_q <= ST_DRAW_RD;
					end
				end
				ST_BCD1: begin
					ones_q  <= 4'(rem_q - tens_x10);
					state_q <= ST_BCD2;
				end
				ST_BCD2: state_q <= ST_DONE;
				ST_ST_RD: state_q <= ST_ST_WR;
				ST_ST_WR: begin
					cnt_q   <= cnt_q + 4'd1;
					state_q <= (cnt_q == xi) ? ST_DONE : ST_ST_RD;
				end
				ST_LD_RD: state_q <= ST_LD_WR;
				ST_LD_WR: begin
					cnt_q   <= cnt_q + 4'd1;
					state_q <= (cnt_q == xi) ? ST_DONE : ST_LD_RD;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!mvalid_q || m_tready) begin
						out_q    <= {row_q, fault_q, chg_q, hit_q, sound_q, delay_q,
							idx_q, pc_q};
						mvalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/bvm_checker.sv
// Port-level checker for the execute unit and its bind
`timescale 1ns / 1ps
`include "bytecode_vm_execute_unit_macros.svh"
module bvm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata
);
	`BVM_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
	`BVM_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed under stall")
	`BVM_ASSERT_NXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "second request taken while busy")
	`BVM_ASSERT_IMP(a_coll_chg, m_tvalid && m_tdata[bvm_pkg::OB_COLL], m_tdata[bvm_pkg::OB_CHG], "collision without change")
endmodule

bind bytecode_vm_execute_unit bvm_checker u_bvm_checker (.*);
